// ===== hw/rtl/inverse_matrix_vector_product_top_defines.svh =====
// Assertion macros for the inverse matrix-vector product block.
// Included by the top level; depends on nothing else.
`ifndef INVERSE_MATRIX_VECTOR_PRODUCT_TOP_DEFINES_SVH
`define INVERSE_MATRIX_VECTOR_PRODUCT_TOP_DEFINES_SVH

// A implies B on the same edge.
`define IMVP_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// A implies B on the next edge.
`define IMVP_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/imvp_pkg.sv =====
// Package for the inverse matrix-vector product block: payload types, codes, sizes.
// Used by every module of the block but imvp_ram; depends on nothing.
`timescale 1ns / 1ps
package imvp_pkg;
    localparam int DEF_MAX_ELECTRODES      = 128;
    localparam int DEF_MAX_POINTS          = 256;
    localparam int DEF_MAX_REGULARIZATIONS = 4;
    localparam int SUM_W  = 40;
    localparam int DATA_W = 16;
    localparam int CFG_W  = 9;
    localparam int QDEPTH = 4;

    localparam logic [1:0] REQ_COEF  = 2'd0;
    localparam logic [1:0] REQ_SAMP  = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    localparam logic [2:0] CFG_VECTOR_MODE = 3'd0;
    localparam logic [2:0] CFG_ACTIVE_REG  = 3'd1;
    localparam logic [2:0] CFG_REGS_USED   = 3'd2;
    localparam logic [2:0] CFG_ELECS_USED  = 3'd3;
    localparam logic [2:0] CFG_POINTS_USED = 3'd4;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [1:0]        matrix_slot;
        logic [9:0]        coef_row;
        logic [6:0]        elec_index;
        logic signed [15:0] data_value;
        logic [7:0]        point_index;
    } req_t;

    typedef struct packed {
        logic [7:0]         point_out;
        logic signed [39:0] sum_x;
        logic signed [39:0] sum_y;
        logic signed [39:0] sum_z;
        logic [39:0]        magnitude;
        logic               range_error;
    } res_t;

    // Classified query handed from front to back.
    typedef struct packed {
        logic       err;
        logic       vec;
        logic [3:0] reg_sel;
        logic [7:0] point;
        logic [8:0] nel;
    } job_t;
endpackage

// ===== hw/rtl/imvp_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module imvp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/imvp_sqrt.sv =====
// Iterative integer square root of an 82-bit value, one result bit per cycle.
// Depends on imvp_pkg.
`timescale 1ns / 1ps
module imvp_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [81:0] radicand,
    output logic        done,
    output logic [40:0] root
);
    import imvp_pkg::*;

    logic [81:0] rem_reg, rem_next;
    logic [40:0] root_reg, root_next;
    logic [81:0] val_reg, val_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [83:0] trial;
    logic [83:0] remsh;

    // Classic restoring digit-by-digit root: two radicand bits per step.
    always_comb
    begin
        rem_next  = rem_reg;
        root_next = root_reg;
        val_next  = val_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        remsh = {rem_reg, val_reg[81:80]};
        trial = {41'd0, root_reg, 2'b01};
        if (go)
        begin
            rem_next  = '0;
            root_next = '0;
            val_next  = radicand;
            cnt_next  = 6'd41;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            val_next = {val_reg[79:0], 2'b00};
            if (remsh >= trial)
            begin
                rem_next  = 82'(remsh - trial);
                root_next = {root_reg[39:0], 1'b1};
            end
            else
            begin
                rem_next  = remsh[81:0];
                root_next = {root_reg[39:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        val_reg  <= val_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

// ===== hw/rtl/imvp_front.sv =====
// Front part: takes requests, performs writes, classifies queries into a job queue.
// Depends on imvp_pkg.
`timescale 1ns / 1ps
module imvp_front #(
    parameter int MAX_ELECTRODES      = 128,
    parameter int MAX_POINTS          = 256,
    parameter int MAX_REGULARIZATIONS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  imvp_pkg::req_t      req,
    input  logic                cfg_vec,
    input  logic [3:0]          cfg_areg,
    input  logic [2:0]          cfg_nreg,
    input  logic [7:0]          cfg_nel,
    input  logic [8:0]          cfg_npt,
    output logic                coef_we,
    output logic [$clog2(MAX_REGULARIZATIONS*3*MAX_POINTS*MAX_ELECTRODES)-1:0] coef_waddr,
    output logic                samp_we,
    output logic [$clog2(MAX_ELECTRODES)-1:0] samp_waddr,
    output logic [15:0]         wdata,
    output logic                job_valid,
    output imvp_pkg::job_t      job,
    input  logic                job_pop,
    input  logic                back_active
);
    import imvp_pkg::*;

    localparam int ROWS  = 3 * MAX_POINTS;
    localparam int CW    = $clog2(MAX_REGULARIZATIONS*3*MAX_POINTS*MAX_ELECTRODES);
    localparam int EW    = $clog2(MAX_ELECTRODES);
    localparam int QW    = $clog2(QDEPTH);

    job_t       q_mem [QDEPTH];
    logic [QW:0] wp_reg, rp_reg, wp_next, rp_next;
    logic        acc;
    job_t        nj;
    logic [3:0]  nreg;
    logic [9:0]  npt;
    logic [8:0]  nel;
    logic        is_q;
    logic        is_wr;
    logic        full;

    assign full = (wp_reg[QW] != rp_reg[QW]) && (wp_reg[QW-1:0] == rp_reg[QW-1:0]);
    assign is_wr = (req.req_type == REQ_COEF) || (req.req_type == REQ_SAMP);
    // Hold a write until every earlier query has finished reading the stores.
    assign busy = full || (is_wr && (job_valid || back_active));
    assign acc  = start && !busy;

    always_comb
    begin
        nreg = (cfg_nreg == 3'd0) ? 4'd1 : {1'b0, cfg_nreg};
        if (32'(nreg) > MAX_REGULARIZATIONS)
        begin
            nreg = 4'(MAX_REGULARIZATIONS);
        end
        nel = (32'(cfg_nel) > MAX_ELECTRODES) ? 9'(MAX_ELECTRODES) : {1'b0, cfg_nel};
        npt = (32'(cfg_npt) > MAX_POINTS) ? 10'(MAX_POINTS) : {1'b0, cfg_npt};
        nj.err     = {2'b0, req.point_index} >= npt;
        nj.vec     = cfg_vec;
        nj.reg_sel = (cfg_areg > nreg - 4'd1) ? nreg - 4'd1 : cfg_areg;
        nj.point   = req.point_index;
        nj.nel     = nel;
    end

    assign is_q = acc && (req.req_type == REQ_QUERY);
    assign coef_we = acc && (req.req_type == REQ_COEF)
                   && (32'(req.matrix_slot) < MAX_REGULARIZATIONS)
                   && (32'(req.coef_row) < ROWS)
                   && (32'(req.elec_index) < MAX_ELECTRODES);
    assign coef_waddr = CW'((32'(req.matrix_slot) * ROWS + 32'(req.coef_row))
                            * MAX_ELECTRODES + 32'(req.elec_index));
    assign samp_we = acc && (req.req_type == REQ_SAMP)
                   && (32'(req.elec_index) < MAX_ELECTRODES);
    assign samp_waddr = EW'(req.elec_index);
    assign wdata = req.data_value;

    always_comb
    begin
        wp_next = wp_reg + (QW+1)'(is_q);
        rp_next = rp_reg + (QW+1)'(job_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_q)
        begin
            q_mem[wp_reg[QW-1:0]] <= nj;
        end
    end

    assign job_valid = wp_reg != rp_reg;
    assign job = q_mem[rp_reg[QW-1:0]];
endmodule

// ===== hw/rtl/imvp_back.sv =====
// Back part: runs queued queries, walks the rows with one MAC, then takes the norm.
// Depends on imvp_pkg and imvp_sqrt.
`timescale 1ns / 1ps
module imvp_back #(
    parameter int MAX_ELECTRODES      = 128,
    parameter int MAX_POINTS          = 256,
    parameter int MAX_REGULARIZATIONS = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           job_valid,
    input  imvp_pkg::job_t job,
    output logic           job_pop,
    output logic [$clog2(MAX_REGULARIZATIONS*3*MAX_POINTS*MAX_ELECTRODES)-1:0] coef_raddr,
    output logic [$clog2(MAX_ELECTRODES)-1:0] samp_raddr,
    input  logic [15:0]    coef_rdata,
    input  logic [15:0]    samp_rdata,
    output logic           done,
    output imvp_pkg::res_t result,
    output logic           active
);
    import imvp_pkg::*;

    localparam int ROWS = 3 * MAX_POINTS;
    localparam int CW   = $clog2(MAX_REGULARIZATIONS*3*MAX_POINTS*MAX_ELECTRODES);
    localparam int EW   = $clog2(MAX_ELECTRODES);
    localparam int XW   = ($clog2(MAX_ELECTRODES) + 33 > SUM_W) ?
                          $clog2(MAX_ELECTRODES) + 33 : SUM_W + 1;
    localparam int HW   = SUM_W / 2;
    localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_ISSUE = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_SQA   = 7'b0001000,
        S_SQB   = 7'b0010000,
        S_ROOT  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t             st_reg, st_next;
    job_t               job_reg, job_next;
    logic [10:0]        e_reg, e_next;
    logic [1:0]         comp_reg, comp_next;
    logic               v1_reg, v2_reg;
    logic signed [31:0] prod_reg;
    logic signed [XW-1:0] acc_reg, acc_next;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg, sx_next, sy_next, sz_next;
    logic [81:0]        sq_reg, sq_next;
    logic [SUM_W-1:0]   phh_reg, phl_reg, pll_reg;
    logic [1:0]         sqi_reg, sqi_next;
    logic               sq_go;
    logic               sq_done;
    logic [40:0]        sq_root;
    logic               done_reg, done_next;
    res_t               res_reg, res_next;
    logic [9:0]         row;
    logic signed [SUM_W-1:0] sat;
    logic [SUM_W-1:0]   absv;
    logic [HW-1:0]      ahi, alo;
    logic signed [SUM_W-1:0] pick;
    logic               issue;
    logic [1:0]         ncomp;

    assign ncomp = job_reg.vec ? 2'd3 : 2'd1;
    assign row = job_reg.vec ? 10'(32'(job_reg.point) * 3 + 32'(comp_reg))
                             : {2'b0, job_reg.point};
    assign coef_raddr = CW'((32'(job_reg.reg_sel) * ROWS + 32'(row)) * MAX_ELECTRODES
                            + 32'(e_reg));
    assign samp_raddr = EW'(e_reg);
    assign issue = (st_reg == S_ISSUE) && (e_reg < 11'(job_reg.nel));
    assign active = (st_reg != S_IDLE);

    always_comb
    begin
        if (acc_reg > XW'(SMAX))
        begin
            sat = SMAX;
        end
        else if (acc_reg < XW'(SMIN))
        begin
            sat = SMIN;
        end
        else
        begin
            sat = SUM_W'(acc_reg);
        end
        case (sqi_reg)
            2'd0:    pick = sx_reg;
            2'd1:    pick = sy_reg;
            default: pick = sz_reg;
        endcase
        absv = pick[SUM_W-1] ? SUM_W'(-pick) : pick;
        ahi  = absv[SUM_W-1:HW];
        alo  = absv[HW-1:0];
    end

    always_comb
    begin
        st_next   = st_reg;
        job_next  = job_reg;
        e_next    = e_reg;
        comp_next = comp_reg;
        acc_next  = acc_reg;
        sx_next   = sx_reg;
        sy_next   = sy_reg;
        sz_next   = sz_reg;
        sq_next   = sq_reg;
        sqi_next  = sqi_reg;
        sq_go     = 1'b0;
        job_pop   = 1'b0;
        done_next = 1'b0;
        res_next  = res_reg;
        if (v2_reg)
        begin
            acc_next = acc_reg + XW'(prod_reg);
        end
        case (st_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop   = 1'b1;
                    job_next  = job;
                    e_next    = '0;
                    comp_next = '0;
                    acc_next  = '0;
                    sx_next   = '0;
                    sy_next   = '0;
                    sz_next   = '0;
                    st_next   = job.err ? S_OUT : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (issue)
                begin
                    e_next = e_reg + 11'd1;
                end
                else
                begin
                    st_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // Wait out the read and multiply stages.
                if (!v1_reg && !v2_reg)
                begin
                    case (comp_reg)
                        2'd0:    sx_next = sat;
                        2'd1:    sy_next = sat;
                        default: sz_next = sat;
                    endcase
                    acc_next = '0;
                    e_next   = '0;
                    if (comp_reg + 2'd1 == ncomp)
                    begin
                        sq_next  = '0;
                        sqi_next = '0;
                        st_next  = S_SQA;
                    end
                    else
                    begin
                        comp_next = comp_reg + 2'd1;
                        st_next   = S_ISSUE;
                    end
                end
            end
            S_SQA:
            begin
                st_next = S_SQB;
            end
            S_SQB:
            begin
                // Square from three half-width partial products.
                sq_next = sq_reg + 82'({phh_reg, {SUM_W{1'b0}}})
                        + 82'({phl_reg, {(HW+1){1'b0}}}) + 82'(pll_reg);
                if (sqi_reg == 2'd2)
                begin
                    st_next = S_ROOT;
                    sq_go   = 1'b1;
                end
                else
                begin
                    sqi_next = sqi_reg + 2'd1;
                    st_next  = S_SQA;
                end
            end
            S_ROOT:
            begin
                if (sq_done)
                begin
                    st_next = S_OUT;
                end
            end
            S_OUT:
            begin
                done_next = 1'b1;
                res_next.point_out   = job_reg.point;
                res_next.sum_x       = sx_reg;
                res_next.sum_y       = sy_reg;
                res_next.sum_z       = sz_reg;
                res_next.magnitude   = job_reg.err ? '0 : sq_root[39:0];
                res_next.range_error = job_reg.err;
                st_next = S_IDLE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    imvp_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (sq_go),
        .radicand (sq_next),
        .done     (sq_done),
        .root     (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
            done_reg <= done_next;
        end
    end

    // Sum of three 40-bit squares stays below 2^81; sqrt fits 41 bits, top bit clear.
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        e_reg    <= e_next;
        comp_reg <= comp_next;
        acc_reg  <= acc_next;
        sx_reg   <= sx_next;
        sy_reg   <= sy_next;
        sz_reg   <= sz_next;
        sq_reg   <= sq_next;
        sqi_reg  <= sqi_next;
        prod_reg <= $signed(coef_rdata) * $signed(samp_rdata);
        phh_reg  <= SUM_W'(ahi) * SUM_W'(ahi);
        phl_reg  <= SUM_W'(ahi) * SUM_W'(alo);
        pll_reg  <= SUM_W'(alo) * SUM_W'(alo);
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

// ===== hw/rtl/inverse_matrix_vector_product_top.sv =====
// Top level of the inverse matrix-vector product block: config registers, stores,
// front and back parts. Depends on imvp_pkg, imvp_ram, imvp_front, imvp_back.
`timescale 1ns / 1ps
// A query walks each row with one MAC per electrode through the single coefficient
// read port, three rows in vector mode, then squares the sums and takes the
// bit-serial root. A four-entry query queue holds queries off (busy) only when full;
// a write is held off while any query is queued or running, so it never changes
// data an earlier query still reads. Results appear on done for one cycle and
// cannot be held off.
`include "inverse_matrix_vector_product_top_defines.svh"
module inverse_matrix_vector_product_top #(
    parameter int MAX_ELECTRODES      = imvp_pkg::DEF_MAX_ELECTRODES,
    parameter int MAX_POINTS          = imvp_pkg::DEF_MAX_POINTS,
    parameter int MAX_REGULARIZATIONS = imvp_pkg::DEF_MAX_REGULARIZATIONS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  imvp_pkg::req_t              req,
    output logic                        done,
    output imvp_pkg::res_t              result,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [imvp_pkg::CFG_W-1:0]  cfg_data
);
    import imvp_pkg::*;

    localparam int CD = MAX_REGULARIZATIONS * 3 * MAX_POINTS * MAX_ELECTRODES;
    localparam int CW = $clog2(CD);
    localparam int EW = $clog2(MAX_ELECTRODES);

    logic        vec_reg;
    logic [3:0]  areg_reg;
    logic [2:0]  nreg_reg;
    logic [7:0]  nel_reg;
    logic [8:0]  npt_reg;
    logic        coef_we, samp_we, job_valid, job_pop, back_active;
    logic [CW-1:0] coef_waddr, coef_raddr;
    logic [EW-1:0] samp_waddr, samp_raddr;
    logic [15:0] wdata, coef_rdata, samp_rdata;
    job_t        job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_reg  <= 1'b0;
            areg_reg <= '0;
            nreg_reg <= 3'd1;
            nel_reg  <= 8'd128;
            npt_reg  <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VECTOR_MODE: vec_reg  <= cfg_data[0];
                CFG_ACTIVE_REG:  areg_reg <= cfg_data[3:0];
                CFG_REGS_USED:   nreg_reg <= cfg_data[2:0];
                CFG_ELECS_USED:  nel_reg  <= cfg_data[7:0];
                CFG_POINTS_USED: npt_reg  <= cfg_data[8:0];
                default:         ;
            endcase
        end
    end

    imvp_front #(
        .MAX_ELECTRODES(MAX_ELECTRODES), .MAX_POINTS(MAX_POINTS),
        .MAX_REGULARIZATIONS(MAX_REGULARIZATIONS)
    ) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .cfg_vec(vec_reg), .cfg_areg(areg_reg), .cfg_nreg(nreg_reg),
        .cfg_nel(nel_reg), .cfg_npt(npt_reg),
        .coef_we(coef_we), .coef_waddr(coef_waddr), .samp_we(samp_we),
        .samp_waddr(samp_waddr), .wdata(wdata),
        .job_valid(job_valid), .job(job), .job_pop(job_pop),
        .back_active(back_active)
    );

    imvp_ram #(.WIDTH(DATA_W), .DEPTH(CD)) u_coef (
        .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(wdata),
        .raddr(coef_raddr), .rdata(coef_rdata)
    );

    imvp_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ELECTRODES)) u_samp (
        .clk(clk), .we(samp_we), .waddr(samp_waddr), .wdata(wdata),
        .raddr(samp_raddr), .rdata(samp_rdata)
    );

    imvp_back #(
        .MAX_ELECTRODES(MAX_ELECTRODES), .MAX_POINTS(MAX_POINTS),
        .MAX_REGULARIZATIONS(MAX_REGULARIZATIONS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
        .job_pop(job_pop), .coef_raddr(coef_raddr), .samp_raddr(samp_raddr),
        .coef_rdata(coef_rdata), .samp_rdata(samp_rdata),
        .done(done), .result(result), .active(back_active)
    );

    `IMVP_ASSERT_IMPL(a_pop_needs_job, clk, rst_n, job_pop, job_valid)
    `IMVP_ASSERT_IMPL(a_err_zero, clk, rst_n, done && result.range_error,
        result.sum_x == 0 && result.magnitude == 0)
    `IMVP_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for inverse_matrix_vector_product_top: random and directed
// requests, an internal predictor, and a result checker. Depends on imvp_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
    import imvp_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int ROWS  = 3 * DEF_MAX_POINTS;
    localparam int DRAIN = 500;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    req_t           req = '0;
    logic           done;
    res_t           result;
    logic           cfg_we = 1'b0;
    logic [2:0]     cfg_index = CFG_VECTOR_MODE;
    logic [CFG_W-1:0] cfg_data = '0;

    inverse_matrix_vector_product_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // register copies, shared by generator and predictor (written only when idle)
    bit         mode_vec = 1'b0;
    logic [3:0] sel_reg = 4'd0;
    logic [2:0] reg_count = 3'd1;
    logic [7:0] elec_count = 8'd128;
    logic [8:0] point_count = 9'd256;

    shortint coef_mem[int];
    shortint sample_mem[int];
    bit      coef_planned[int];
    bit      sample_planned[int];

    req_t    request_queue[$];
    res_t    expected_solutions[$];
    int      idle_pct = 0;
    bit      taken = 1'b0;
    int      errors = 0;
    int      n_queries = 0;
    int      n_writes = 0;
    int      n_range = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int eff_regs();
        int n;
        n = reg_count;
        if (n < 1) n = 1;
        if (n > DEF_MAX_REGULARIZATIONS) n = DEF_MAX_REGULARIZATIONS;
        return n;
    endfunction

    function automatic int eff_reg();
        return (sel_reg > eff_regs() - 1) ? eff_regs() - 1 : sel_reg;
    endfunction

    function automatic int eff_elecs();
        return (elec_count > DEF_MAX_ELECTRODES) ? DEF_MAX_ELECTRODES : elec_count;
    endfunction

    function automatic int eff_points();
        return (point_count > DEF_MAX_POINTS) ? DEF_MAX_POINTS : point_count;
    endfunction

    function automatic longint row_sum(int sel, int row, int nel);
        longint acc;
        acc = 0;
        for (int e = 0; e < nel; e++)
            acc += longint'(coef_mem[(sel * ROWS + row) * DEF_MAX_ELECTRODES + e])
                 * longint'(sample_mem[e]);
        if (acc > 64'sd549755813887) acc = 64'sd549755813887;
        if (acc < -64'sd549755813888) acc = -64'sd549755813888;
        return acc;
    endfunction

    function automatic logic [39:0] root_of(longint x, longint y, longint z);
        logic [127:0] ax, ay, az, v, r, t;
        ax = (x < 0) ? 128'(-x) : 128'(x);
        ay = (y < 0) ? 128'(-y) : 128'(y);
        az = (z < 0) ? 128'(-z) : 128'(z);
        v = ax * ax + ay * ay + az * az;
        r = '0;
        for (int b = 40; b >= 0; b--) begin
            t = r | (128'd1 << b);
            if (t * t <= v) r = t;
        end
        return (r > 128'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : r[39:0];
    endfunction

    // update the store copies and work out the result a transaction causes
    task automatic solve_point(req_t r);
        res_t    s;
        longint  x, y, z;
        int      pt;
        case (r.req_type)
            REQ_COEF:
                if (r.coef_row < ROWS)
                    coef_mem[(r.matrix_slot * ROWS + r.coef_row) * DEF_MAX_ELECTRODES
                             + r.elec_index] = r.data_value;
            REQ_SAMP:
                sample_mem[r.elec_index] = r.data_value;
            REQ_QUERY:
            begin
                pt = r.point_index;
                x = 0;
                y = 0;
                z = 0;
                s = '0;
                s.point_out = r.point_index;
                s.range_error = (pt >= eff_points());
                if (!s.range_error) begin
                    if (mode_vec) begin
                        x = row_sum(eff_reg(), 3 * pt, eff_elecs());
                        y = row_sum(eff_reg(), 3 * pt + 1, eff_elecs());
                        z = row_sum(eff_reg(), 3 * pt + 2, eff_elecs());
                    end
                    else begin
                        x = row_sum(eff_reg(), pt, eff_elecs());
                    end
                    s.magnitude = root_of(x, y, z);
                end
                s.sum_x = x[39:0];
                s.sum_y = y[39:0];
                s.sum_z = z[39:0];
                expected_solutions.push_back(s);
            end
            default: ;
        endcase
    endtask

    // drive the next transaction at the falling edge
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else if (!start || taken) begin
            if (request_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
                req   <= request_queue.pop_front();
                start <= 1'b1;
            end
            else begin
                start <= 1'b0;
            end
        end
    end

    // check results first, then predict the transaction accepted at this edge
    always @(posedge clk) begin
        taken = 1'b0;
        if (rst_n) begin
            if (done) begin
                if (expected_solutions.size() == 0) begin
                    $error("result with no query outstanding, point %0d", result.point_out);
                    errors++;
                end
                else begin
                    res_t e;
                    e = expected_solutions.pop_front();
                    if (result.point_out !== e.point_out) begin
                        $error("point_out expected %0d actual %0d", e.point_out,
                               result.point_out);
                        errors++;
                    end
                    if (result.sum_x !== e.sum_x) begin
                        $error("sum_x expected %0d actual %0d", e.sum_x, result.sum_x);
                        errors++;
                    end
                    if (result.sum_y !== e.sum_y) begin
                        $error("sum_y expected %0d actual %0d", e.sum_y, result.sum_y);
                        errors++;
                    end
                    if (result.sum_z !== e.sum_z) begin
                        $error("sum_z expected %0d actual %0d", e.sum_z, result.sum_z);
                        errors++;
                    end
                    if (result.magnitude !== e.magnitude) begin
                        $error("magnitude expected %0d actual %0d", e.magnitude,
                               result.magnitude);
                        errors++;
                    end
                    if (result.range_error !== e.range_error) begin
                        $error("range_error expected %0d actual %0d", e.range_error,
                               result.range_error);
                        errors++;
                    end
                end
            end
            taken = start && !busy;
            if (taken) solve_point(req);
        end
    end

    function automatic shortint pick_data();
        case ($urandom_range(9))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            default: return shortint'($urandom);
        endcase
    endfunction

    function automatic req_t noise_req(logic [1:0] kind);
        req_t r;
        r = req_t'($bits(req_t)'({$urandom, $urandom}));
        r.req_type = kind;
        return r;
    endfunction

    task automatic push_coef(int slot, int row, int elec, shortint d);
        req_t r;
        r = noise_req(REQ_COEF);
        r.matrix_slot = 2'(slot);
        r.coef_row = 10'(row);
        r.elec_index = 7'(elec);
        r.data_value = d;
        if (row < ROWS) coef_planned[(slot * ROWS + row) * DEF_MAX_ELECTRODES + elec] = 1'b1;
        request_queue.push_back(r);
        n_writes++;
    endtask

    task automatic push_sample(int elec, shortint d);
        req_t r;
        r = noise_req(REQ_SAMP);
        r.elec_index = 7'(elec);
        r.data_value = d;
        sample_planned[elec] = 1'b1;
        request_queue.push_back(r);
        n_writes++;
    endtask

    // fill whatever the query would read that was never written, then query
    task automatic push_query(int pt);
        req_t r;
        int   row;
        if (pt < eff_points()) begin
            for (int k = 0; k < (mode_vec ? 3 : 1); k++) begin
                row = mode_vec ? 3 * pt + k : pt;
                for (int e = 0; e < eff_elecs(); e++)
                    if (!coef_planned.exists((eff_reg() * ROWS + row) * DEF_MAX_ELECTRODES + e))
                        push_coef(eff_reg(), row, e, pick_data());
            end
            for (int e = 0; e < eff_elecs(); e++)
                if (!sample_planned.exists(e)) push_sample(e, pick_data());
        end
        else begin
            n_range++;
        end
        r = noise_req(REQ_QUERY);
        r.point_index = 8'(pt);
        request_queue.push_back(r);
        n_queries++;
    endtask

    task automatic wait_idle();
        while (request_queue.size() != 0 || start || expected_solutions.size() != 0)
            @(posedge clk);
        // let a trailing write finish before touching the registers
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_VECTOR_MODE: mode_vec = val[0];
            CFG_ACTIVE_REG:  sel_reg = val[3:0];
            CFG_REGS_USED:   reg_count = val[2:0];
            CFG_ELECS_USED:  elec_count = val[7:0];
            CFG_POINTS_USED: point_count = val[8:0];
            default: ;
        endcase
    endtask

    task automatic setup(int vec, int sel, int nr, int nel, int npt);
        write_reg(CFG_VECTOR_MODE, vec);
        write_reg(CFG_ACTIVE_REG, sel);
        write_reg(CFG_REGS_USED, nr);
        write_reg(CFG_ELECS_USED, nel);
        write_reg(CFG_POINTS_USED, npt);
    endtask

    // random requests centered on a few hot points so that rows get reused
    task automatic run_random(int count, int idle, bit hot_only);
        int hot[4];
        int pt;
        int roll;
        idle_pct = idle;
        foreach (hot[i]) hot[i] = $urandom_range(eff_points() - 1);
        hot[0] = eff_points() - 1;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 30) begin
                pt = hot[$urandom_range(3)];
                push_coef($urandom_range(3), mode_vec ? 3 * pt + $urandom_range(2) : pt,
                          $urandom_range(DEF_MAX_ELECTRODES - 1), pick_data());
            end
            else if (roll < 35) begin
                push_coef($urandom_range(3), $urandom_range(1023, ROWS),
                          $urandom_range(127), pick_data());
            end
            else if (roll < 55) begin
                push_sample($urandom_range(DEF_MAX_ELECTRODES - 1), pick_data());
            end
            else if (roll < 60) begin
                request_queue.push_back(noise_req(REQ_UNUSED));
            end
            else begin
                roll = $urandom_range(9);
                if (roll < 7 || hot_only)
                    pt = hot[$urandom_range(3)];
                else if (roll < 9)
                    pt = $urandom_range(eff_points() - 1);
                else
                    pt = $urandom_range(255);
                push_query(pt);
            end
        end
        wait_idle();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes of data, ignored writes, unknown request, range edges
        setup(0, 0, 1, 3, 200);
        push_sample(0, -16'sd32768);
        push_sample(1, 16'sd32767);
        push_sample(2, -16'sd1);
        push_coef(0, 0, 0, -16'sd32768);
        push_coef(0, 0, 1, 16'sd32767);
        push_coef(0, 0, 2, 16'sd1);
        push_coef(3, 1023, 127, 16'sd32767);
        push_coef(2, ROWS, 5, -16'sd32768);
        request_queue.push_back(noise_req(REQ_UNUSED));
        push_query(0);
        push_query(199);
        push_query(200);
        push_query(255);
        push_coef(0, 0, 0, 16'sd32767);
        push_query(0);
        wait_idle();

        setup(1, 2, 4, 4, 20);
        run_random(50, 52, 1'b0);
        setup(1, 15, 3, 1, 1);
        run_random(60, 0, 1'b0);
        setup(0, 1, 0, 0, 300);
        run_random(60, 18, 1'b0);
        setup(1, 3, 7, 6, 256);
        run_random(20, 52, 1'b1);
        setup(0, 3, 4, 200, 1);
        run_random(30, 18, 1'b1);
        setup(1, 1, 2, 3, 256);
        run_random(80, 0, 1'b0);
        setup(0, 2, 3, 8, 128);
        run_random(60, 52, 1'b0);

        repeat (DRAIN) @(posedge clk);
        $display("Covered %0d queries (%0d out of range) and %0d coefficient/sample writes",
                 n_queries, n_range, n_writes);
        $display("over scalar and vector modes, clipped register settings and idle mixes.");
        if (errors == 0 && expected_solutions.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
